@@ hdl/jise_pkg.sv @@
// Package with opcodes, status codes, kinds and sequencer types for the stack executor.
`timescale 1ns / 1ps
package jise_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RET    = 3'd1,
        ST_OVF    = 3'd2,
        ST_UNF    = 3'd3,
        ST_DIV0   = 3'd4,
        ST_UNSUP  = 3'd5,
        ST_BADLOC = 3'd6
    } t_status;

    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_REF   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // Operations of the shared arithmetic unit.
    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_SHL, ALU_SAR, ALU_SHR,
        ALU_AND, ALU_OR, ALU_XOR, ALU_NEG, ALU_PASS
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    is_long;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_READ, S_EXEC, S_WAIT, S_WRITE, S_RESULT
    } t_state;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_ACONST   = 8'h01;
    localparam logic [7:0] OP_BIPUSH   = 8'h10;
    localparam logic [7:0] OP_SIPUSH   = 8'h11;
    localparam logic [7:0] OP_ILOAD    = 8'h15;
    localparam logic [7:0] OP_LLOAD    = 8'h16;
    localparam logic [7:0] OP_ALOAD    = 8'h19;
    localparam logic [7:0] OP_ISTORE   = 8'h36;
    localparam logic [7:0] OP_LSTORE   = 8'h37;
    localparam logic [7:0] OP_ASTORE   = 8'h3a;
    localparam logic [7:0] OP_POP      = 8'h57;
    localparam logic [7:0] OP_DUP      = 8'h59;
    localparam logic [7:0] OP_SWAP     = 8'h5f;
    localparam logic [7:0] OP_INEG     = 8'h74;
    localparam logic [7:0] OP_LNEG     = 8'h75;
    localparam logic [7:0] OP_I2L      = 8'h85;
    localparam logic [7:0] OP_L2I      = 8'h88;
    localparam logic [7:0] OP_I2B      = 8'h91;
    localparam logic [7:0] OP_I2C      = 8'h92;
    localparam logic [7:0] OP_I2S      = 8'h93;
    localparam logic [7:0] OP_IRETURN  = 8'hac;
    localparam logic [7:0] OP_LRETURN  = 8'had;
    localparam logic [7:0] OP_ARETURN  = 8'hb0;
    localparam logic [7:0] OP_RETURN   = 8'hb1;

endpackage

@@ hdl/jise_alu.sv @@
// Shared arithmetic unit: direct logic ops, stepped multiply, bit-serial divide.
`timescale 1ns / 1ps
module jise_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jise_pkg::t_alu_req  i_req,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output logic [63:0]         o_result
);
    import jise_pkg::*;

    t_alu_op     r_op,    n_op;
    logic        r_long,  n_long;
    logic        r_busy,  n_busy;
    logic [6:0]  r_cnt,   n_cnt;
    logic [63:0] r_a,     n_a;
    logic [63:0] r_b,     n_b;
    logic [63:0] r_acc,   n_acc;
    logic [63:0] r_rem,   n_rem;
    logic        r_negq,  n_negq;
    logic        r_negr,  n_negr;
    logic        r_done,  n_done;
    logic [63:0] r_res,   n_res;

    logic [63:0] a_in, b_in;
    logic [5:0]  shamt;
    logic [63:0] quick;
    logic [64:0] trial;
    logic [63:0] rem_sh;
    logic [63:0] q_fin, r_fin;

    always_comb begin
        a_in = i_req.is_long ? i_a : {{32{i_a[31]}}, i_a[31:0]};
        b_in = i_req.is_long ? i_b : {{32{i_b[31]}}, i_b[31:0]};
        shamt = i_req.is_long ? i_b[5:0] : {1'b0, i_b[4:0]};
        unique case (i_req.op)
            ALU_ADD:  quick = a_in + b_in;
            ALU_SUB:  quick = a_in - b_in;
            ALU_SHL:  quick = a_in << shamt;
            ALU_SAR:  quick = $signed(a_in) >>> shamt;
            ALU_SHR:  quick = i_req.is_long ? (i_a >> shamt) : ({32'd0, i_a[31:0]} >> shamt);
            ALU_AND:  quick = a_in & b_in;
            ALU_OR:   quick = a_in | b_in;
            ALU_XOR:  quick = a_in ^ b_in;
            ALU_NEG:  quick = 64'd0 - a_in;
            default:  quick = a_in;
        endcase
    end

    always_comb begin
        rem_sh = {r_rem[62:0], r_a[63]};
        trial  = {1'b0, rem_sh} - {1'b0, r_b};
        q_fin  = r_negq ? 64'd0 - r_acc : r_acc;
        r_fin  = r_negr ? 64'd0 - r_rem : r_rem;
    end

    always_comb begin
        n_op = r_op; n_long = r_long; n_busy = r_busy; n_cnt = r_cnt;
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_rem = r_rem;
        n_negq = r_negq; n_negr = r_negr; n_done = 1'b0; n_res = r_res;
        if (i_req.start) begin
            n_op = i_req.op;
            n_long = i_req.is_long;
            n_cnt = 7'd0;
            if (i_req.op == ALU_MUL) begin
                n_busy = 1'b1;
                n_a = a_in;
                n_b = b_in;
                n_acc = 64'd0;
            end else if (i_req.op == ALU_DIV || i_req.op == ALU_REM) begin
                // Magnitudes are divided; signs are restored at the end.
                n_busy = 1'b1;
                n_a = a_in[63] ? 64'd0 - a_in : a_in;
                n_b = b_in[63] ? 64'd0 - b_in : b_in;
                n_acc = 64'd0;
                n_rem = 64'd0;
                n_negq = a_in[63] ^ b_in[63];
                n_negr = a_in[63];
            end else begin
                n_done = 1'b1;
                n_res = quick;
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                // 16 bits of the multiplier per cycle.
                n_acc = r_acc + ((r_a * {48'd0, r_b[15:0]}) << {r_cnt[1:0], 4'd0});
                n_b = r_b >> 16;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_res = n_acc;
                end
            end else begin
                n_a = {r_a[62:0], 1'b0};
                if (!trial[64]) begin
                    n_rem = trial[63:0];
                    n_acc = {r_acc[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_acc = {r_acc[62:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_a = r_a; n_acc = r_acc; n_rem = r_rem;
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_res = (r_op == ALU_DIV) ? q_fin : r_fin;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op <= n_op; r_long <= n_long; r_a <= n_a; r_b <= n_b; r_acc <= n_acc;
        r_rem <= n_rem; r_negq <= n_negq; r_negr <= n_negr; r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_long ? r_res : {{32{r_res[31]}}, r_res[31:0]};

endmodule

@@ hdl/jvm_integer_stack_executor_top.sv @@
// Top level of the bytecode stack executor: decoder, sequencer, stack and locals.
`timescale 1ns / 1ps
// Executes one Java bytecode (opcode plus 16-bit immediate) per accepted word on a
// typed operand stack and local-variable store held in memories, and returns one
// result word with the new top of stack, its kind, the depth and a status. Constants,
// loads, stores, stack ops, conversions, returns and every error finish without the
// shared arithmetic unit; int and long add, subtract, shift and logic ops use it,
// multiplies take four passes through its multiplier and divide and remainder run
// on its bit-serial divider. The block takes the next word only in the cycle after
// the result word has been taken, so it never accepts a word while the previous one
// is still in flight. Errors leave all state unchanged.
module jvm_integer_stack_executor_top #(
    parameter int STACK_DEPTH = 16,
    parameter int LOCAL_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_opcode,
    input  logic signed [15:0] i_operand,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_top_value,
    output logic [1:0]         o_top_kind,
    output logic [4:0]         o_depth,
    output logic [2:0]         o_status
);
    import jise_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // Decoded operation classes.
    typedef enum logic [3:0] {
        C_NONE, C_PUSH, C_LOAD, C_STORE, C_POP, C_DUP, C_SWAP, C_BIN, C_UN,
        C_VRET, C_RET, C_UNSUP
    } t_cls;

    t_state      r_state, n_state;
    logic [7:0]  r_op;
    logic [15:0] r_imm;
    t_cls        r_cls;
    logic [63:0] r_pval;
    logic [1:0]  r_pkind;
    logic [15:0] r_lidx;
    t_alu_op     r_aop;
    logic        r_along;
    logic [1:0]  r_ukind;
    logic [DW-1:0] r_depth;
    logic [63:0] r_x, r_y;      // top and second entry
    logic [1:0]  r_kx, r_ky;
    logic [63:0] r_lv;
    logic [1:0]  r_lk;
    logic [2:0]  r_st;
    logic [63:0] r_res;
    logic        r_ovalid;
    logic [63:0] r_otv;
    logic [1:0]  r_otk;
    logic [4:0]  r_odep;
    logic [2:0]  r_ost;

    logic [63:0] stk_v [STACK_DEPTH];
    logic [1:0]  stk_k [STACK_DEPTH];
    logic [63:0] loc_v [LOCAL_COUNT];
    logic [1:0]  loc_k [LOCAL_COUNT];

    t_alu_req    alu_req;
    logic        alu_done;
    logic [63:0] alu_res;

    jise_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_y),
        .i_b     (r_x),
        .o_done  (alu_done),
        .o_result(alu_res)
    );

    // Decode.
    t_cls        d_cls;
    logic [63:0] d_pval;
    logic [1:0]  d_pkind;
    logic [15:0] d_lidx;
    t_alu_op     d_aop;
    logic        d_along;
    logic [1:0]  d_ukind;
    logic [7:0]  d_sub;

    always_comb begin
        d_cls = C_UNSUP; d_pval = 64'd0; d_pkind = KIND_INT; d_lidx = 16'd0;
        d_aop = ALU_PASS; d_along = r_op[0]; d_ukind = KIND_INT;
        d_sub = r_op - 8'h1a;
        if (r_op >= 8'h02 && r_op <= 8'h08) begin
            d_cls = C_PUSH;
            d_pval = {{56{r_op < 8'd3}}, r_op - 8'd3};
        end else if ((r_op >= 8'h1a && r_op <= 8'h21) || (r_op >= 8'h2a && r_op <= 8'h2d)) begin
            d_cls = C_LOAD; d_lidx = {14'd0, d_sub[1:0]};
        end else if ((r_op >= 8'h3b && r_op <= 8'h42) || (r_op >= 8'h4b && r_op <= 8'h4e)) begin
            d_cls = C_STORE; d_lidx = {14'd0, r_op[1:0] - 2'd3};
        end else begin
            case (r_op)
                OP_NOP:     d_cls = C_NONE;
                OP_ACONST:  begin d_cls = C_PUSH; d_pkind = KIND_REF; end
                8'h09, 8'h0a: begin
                    d_cls = C_PUSH; d_pkind = KIND_LONG; d_pval = {63'd0, r_op[0] ^ 1'b1};
                end
                OP_BIPUSH:  begin d_cls = C_PUSH; d_pval = {{56{r_imm[7]}}, r_imm[7:0]}; end
                OP_SIPUSH:  begin d_cls = C_PUSH; d_pval = {{48{r_imm[15]}}, r_imm}; end
                OP_ILOAD, OP_LLOAD, OP_ALOAD:    begin d_cls = C_LOAD; d_lidx = r_imm; end
                OP_ISTORE, OP_LSTORE, OP_ASTORE: begin d_cls = C_STORE; d_lidx = r_imm; end
                OP_POP:  d_cls = C_POP;
                OP_DUP:  d_cls = C_DUP;
                OP_SWAP: d_cls = C_SWAP;
                8'h60, 8'h61: begin d_cls = C_BIN; d_aop = ALU_ADD; end
                8'h64, 8'h65: begin d_cls = C_BIN; d_aop = ALU_SUB; end
                8'h68, 8'h69: begin d_cls = C_BIN; d_aop = ALU_MUL; end
                8'h6c, 8'h6d: begin d_cls = C_BIN; d_aop = ALU_DIV; end
                8'h70, 8'h71: begin d_cls = C_BIN; d_aop = ALU_REM; end
                8'h78, 8'h79: begin d_cls = C_BIN; d_aop = ALU_SHL; end
                8'h7a, 8'h7b: begin d_cls = C_BIN; d_aop = ALU_SAR; end
                8'h7c, 8'h7d: begin d_cls = C_BIN; d_aop = ALU_SHR; end
                8'h7e, 8'h7f: begin d_cls = C_BIN; d_aop = ALU_AND; end
                8'h80, 8'h81: begin d_cls = C_BIN; d_aop = ALU_OR; end
                8'h82, 8'h83: begin d_cls = C_BIN; d_aop = ALU_XOR; end
                OP_INEG: begin d_cls = C_UN; d_aop = ALU_NEG; d_along = 1'b0; end
                OP_LNEG: begin
                    d_cls = C_UN; d_aop = ALU_NEG; d_along = 1'b1; d_ukind = KIND_LONG;
                end
                OP_I2L: begin
                    d_cls = C_UN; d_along = 1'b0; d_ukind = KIND_LONG;
                end
                OP_L2I, OP_I2B, OP_I2C, OP_I2S: begin d_cls = C_UN; d_along = 1'b0; end
                OP_IRETURN, OP_LRETURN, OP_ARETURN: d_cls = C_RET;
                OP_RETURN: d_cls = C_VRET;
                default: d_cls = C_UNSUP;
            endcase
        end
    end

    logic [DW-1:0] dep_m1, dep_m2;
    logic [SW-1:0] ix_top, ix_sec, ix_push;
    logic [LW-1:0] lix;
    logic          bad_loc;
    logic [31:0]   ineg;
    logic [63:0]   un_res;
    logic [2:0]    ex_st;

    always_comb begin
        dep_m1  = r_depth - DW'(1);
        dep_m2  = r_depth - DW'(2);
        ix_top  = dep_m1[SW-1:0];
        ix_sec  = dep_m2[SW-1:0];
        ix_push = r_depth[SW-1:0];
        lix     = r_lidx[LW-1:0];
        bad_loc = {16'd0, r_lidx} >= 32'(LOCAL_COUNT);
        ineg    = 32'd0 - r_x[31:0];
        case (r_op)
            OP_INEG: un_res = {{32{ineg[31]}}, ineg};
            OP_LNEG: un_res = 64'd0 - r_x;
            OP_I2B:  un_res = {{56{r_x[7]}}, r_x[7:0]};
            OP_I2C:  un_res = {48'd0, r_x[15:0]};
            OP_I2S:  un_res = {{48{r_x[15]}}, r_x[15:0]};
            default: un_res = {{32{r_x[31]}}, r_x[31:0]};
        endcase
    end

    // Status of the current word, from the entries read in the previous step.
    always_comb begin
        ex_st = ST_OK;
        unique case (r_cls)
            C_PUSH:  if (r_depth >= DW'(STACK_DEPTH)) ex_st = ST_OVF;
            C_LOAD:  if (bad_loc) ex_st = ST_BADLOC;
                     else if (r_depth >= DW'(STACK_DEPTH)) ex_st = ST_OVF;
            C_STORE: if (bad_loc) ex_st = ST_BADLOC;
                     else if (r_depth == '0) ex_st = ST_UNF;
            C_POP, C_UN: if (r_depth == '0) ex_st = ST_UNF;
            C_DUP:   if (r_depth == '0) ex_st = ST_UNF;
                     else if (r_depth >= DW'(STACK_DEPTH)) ex_st = ST_OVF;
            C_SWAP:  if (r_depth < DW'(2)) ex_st = ST_UNF;
            C_BIN:   if (r_depth < DW'(2)) ex_st = ST_UNF;
                     else if ((r_aop == ALU_DIV || r_aop == ALU_REM) &&
                              (r_along ? (r_x == 64'd0) : (r_x[31:0] == 32'd0)))
                         ex_st = ST_DIV0;
            C_RET:   ex_st = (r_depth == '0) ? ST_UNF : ST_RET;
            C_VRET:  ex_st = ST_RET;
            C_UNSUP: ex_st = ST_UNSUP;
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid && !r_ovalid) n_state = S_DECODE;
            S_DECODE: n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC:   n_state = (r_cls == C_BIN && ex_st == ST_OK) ? S_WAIT : S_WRITE;
            S_WAIT:   if (alu_done) n_state = S_WRITE;
            S_WRITE:  n_state = S_RESULT;
            S_RESULT: if (!r_ovalid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_ready       = (r_state == S_IDLE) && !r_ovalid;
        alu_req.start = (r_state == S_EXEC) && (r_cls == C_BIN) && (ex_st == ST_OK);
        alu_req.op    = r_aop;
        alu_req.is_long = r_along;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_WRITE && r_st == ST_OK) begin
                unique case (r_cls)
                    C_PUSH, C_LOAD, C_DUP: r_depth <= r_depth + DW'(1);
                    C_STORE, C_POP, C_BIN: r_depth <= dep_m1;
                    default: ;
                endcase
            end
            if (r_state == S_RESULT && !r_ovalid) r_ovalid <= 1'b1;
        end
        if (r_state == S_IDLE && i_valid && !r_ovalid) begin
            r_op  <= i_opcode;
            r_imm <= i_operand;
        end
        if (r_state == S_DECODE) begin
            r_cls <= d_cls; r_pval <= d_pval; r_pkind <= d_pkind; r_lidx <= d_lidx;
            r_aop <= d_aop; r_along <= d_along; r_ukind <= d_ukind;
        end
        // Memory reads: top, second and the addressed local.
        if (r_state == S_READ) begin
            r_x  <= stk_v[ix_top]; r_kx <= stk_k[ix_top];
            r_y  <= stk_v[ix_sec]; r_ky <= stk_k[ix_sec];
            r_lv <= loc_v[lix];    r_lk <= loc_k[lix];
        end
        if (r_state == S_EXEC) begin
            r_st  <= ex_st;
            r_res <= un_res;
        end
        if (r_state == S_WAIT && alu_done) r_res <= alu_res;
        // Stack and local writes; results go out from a register after this.
        if (r_state == S_WRITE && r_st == ST_OK) begin
            unique case (r_cls)
                C_PUSH: begin stk_v[ix_push] <= r_pval; stk_k[ix_push] <= r_pkind; end
                C_LOAD: begin stk_v[ix_push] <= r_lv;   stk_k[ix_push] <= r_lk; end
                C_DUP:  begin stk_v[ix_push] <= r_x;    stk_k[ix_push] <= r_kx; end
                C_STORE: begin loc_v[lix] <= r_x; loc_k[lix] <= r_kx; end
                C_SWAP: begin
                    stk_v[ix_top] <= r_y; stk_k[ix_top] <= r_ky;
                    stk_v[ix_sec] <= r_x; stk_k[ix_sec] <= r_kx;
                end
                C_BIN: begin
                    stk_v[ix_sec] <= r_res;
                    stk_k[ix_sec] <= r_along ? KIND_LONG : KIND_INT;
                end
                C_UN: begin stk_v[ix_top] <= r_res; stk_k[ix_top] <= r_ukind; end
                default: ;
            endcase
        end
        // Build the result word from what the write step leaves.
        if (r_state == S_WRITE) begin
            r_ost <= r_st;
            r_odep <= 5'd0;
            if (r_cls == C_VRET) begin
                r_otv <= 64'd0; r_otk <= KIND_INT;
                r_odep <= 5'(r_depth);
            end else if (r_st != ST_OK) begin
                r_odep <= 5'(r_depth);
                r_otv <= (r_depth == '0) ? 64'd0 : r_x;
                r_otk <= (r_depth == '0) ? KIND_EMPTY : r_kx;
            end else begin
                unique case (r_cls)
                    C_PUSH: begin r_otv <= r_pval; r_otk <= r_pkind;
                        r_odep <= 5'(r_depth + DW'(1)); end
                    C_LOAD: begin r_otv <= r_lv; r_otk <= r_lk;
                        r_odep <= 5'(r_depth + DW'(1)); end
                    C_DUP: begin r_otv <= r_x; r_otk <= r_kx;
                        r_odep <= 5'(r_depth + DW'(1)); end
                    C_STORE, C_POP: begin
                        r_otv <= (dep_m1 == '0) ? 64'd0 : r_y;
                        r_otk <= (dep_m1 == '0) ? KIND_EMPTY : r_ky;
                        r_odep <= 5'(dep_m1);
                    end
                    C_SWAP: begin r_otv <= r_y; r_otk <= r_ky; r_odep <= 5'(r_depth); end
                    C_BIN: begin
                        r_otv <= r_res; r_otk <= r_along ? KIND_LONG : KIND_INT;
                        r_odep <= 5'(dep_m1);
                    end
                    C_UN: begin r_otv <= r_res; r_otk <= r_ukind; r_odep <= 5'(r_depth); end
                    default: begin
                        r_odep <= 5'(r_depth);
                        r_otv <= (r_depth == '0) ? 64'd0 : r_x;
                        r_otk <= (r_depth == '0) ? KIND_EMPTY : r_kx;
                    end
                endcase
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_top_value = r_otv;
    assign o_top_kind  = r_otk;
    assign o_depth     = r_odep;
    assign o_status    = r_ost;

endmodule
